@@ hw/rtl/hhi_pkg.sv @@
// shared constants, codes and controller/datapath interface types of the hopscotch index
package hhi_pkg;

  localparam int BUCKET_BITS = 10;
  localparam int HOP_RANGE   = 32;
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int STORE_SLOTS = NUM_BUCKETS + HOP_RANGE;
  localparam int ADDR_W      = $clog2(STORE_SLOTS);
  localparam int CNT_W       = $clog2(STORE_SLOTS + 1);
  localparam int IDX_W       = $clog2(HOP_RANGE + 1);
  localparam int DIST_W      = $clog2(HOP_RANGE);

  // slot layout
  localparam int SLOT_W    = 64;
  localparam int VALID_POS = 63;
  localparam int OFF_LSB   = 58;
  localparam int TAG_LSB   = 50;
  localparam int KV_LSB    = 34;
  localparam int OFF_W     = 5;
  localparam int TAG_W     = 8;
  localparam int KV_W      = 16;
  localparam int PBA_W     = 34;
  localparam int HASH_W    = 64;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_HOLE_RD, S_HOLE_CHK,
    S_WIN, S_MV_RD, S_MV_CHK, S_MV_CLR, S_DONE
  } state_t;

  typedef enum logic [1:0] {ASEL_CLR, ASEL_IDX, ASEL_HOLE, ASEL_CAND} asel_t;
  typedef enum logic [1:0] {WSEL_ZERO, WSEL_MOVED, WSEL_NEW} wsel_t;

  typedef struct packed {
    logic       load_in;
    logic       idx_start;
    logic       idx_zero;
    logic       idx_inc;
    logic       hole_init;
    logic       hole_inc;
    logic       hole_to_cand;
    logic       dist_init;
    logic       dist_dec;
    logic       clr_inc;
    logic       rd_en;
    logic       wr_en;
    asel_t      asel;
    wsel_t      wsel;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_use_slot;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       start_oob;
    logic       lk_match;
    logic       rm_match;
    logic       idx_last;
    logic       slot_valid;
    logic       hole_end;
    logic       in_window;
    logic       cand_below;
    logic       dist_zero;
    logic       move_ok;
    logic       clr_done;
    logic       out_busy;
  } stat_t;

endpackage

@@ hw/rtl/hhi_ram.sv @@
// generic single-write, single-read ram with registered read data
module hhi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/hhi_ctrl.sv @@
// controller state machine sequencing lookup, insert, remove and the clearing pass
module hhi_ctrl import hhi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_accept,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.asel   = ASEL_IDX;
    cmd.wsel   = WSEL_ZERO;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.asel    = ASEL_CLR;
        cmd.clr_inc = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_accept) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_LOOKUP: begin
            if (stat.start_oob) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NOT_FOUND;
              state_next     = S_DONE;
            end else begin
              cmd.idx_start = 1'b1;
              state_next    = S_SCAN_RD;
            end
          end
          OP_REMOVE: begin
            cmd.idx_zero = 1'b1;
            state_next   = S_SCAN_RD;
          end
          OP_INSERT: begin
            cmd.hole_init = 1'b1;
            state_next    = S_HOLE_RD;
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_next     = S_DONE;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if ((stat.op == OP_LOOKUP && stat.lk_match) ||
            (stat.op == OP_REMOVE && stat.rm_match)) begin
          cmd.res_set      = 1'b1;
          cmd.res_status   = ST_OK;
          cmd.res_use_slot = 1'b1;
          cmd.wr_en        = (stat.op == OP_REMOVE);
          state_next       = S_DONE;
        end else if (stat.idx_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_HOLE_RD: begin
        cmd.asel = ASEL_HOLE;
        if (stat.hole_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
          state_next     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_HOLE_CHK;
        end
      end
      S_HOLE_CHK: begin
        if (stat.slot_valid) begin
          cmd.hole_inc = 1'b1;
          state_next   = S_HOLE_RD;
        end else begin
          state_next = S_WIN;
        end
      end
      S_WIN: begin
        cmd.asel = ASEL_HOLE;
        if (stat.in_window) begin
          cmd.wr_en      = 1'b1;
          cmd.wsel       = WSEL_NEW;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_DONE;
        end else begin
          cmd.dist_init = 1'b1;
          state_next    = S_MV_RD;
        end
      end
      S_MV_RD: begin
        cmd.asel = ASEL_CAND;
        if (stat.dist_zero || stat.cand_below) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
          state_next     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_MV_CHK;
        end
      end
      S_MV_CHK: begin
        cmd.asel = ASEL_HOLE;
        if (stat.move_ok) begin
          cmd.wr_en  = 1'b1;
          cmd.wsel   = WSEL_MOVED;
          state_next = S_MV_CLR;
        end else begin
          cmd.dist_dec = 1'b1;
          state_next   = S_MV_RD;
        end
      end
      S_MV_CLR: begin
        cmd.asel         = ASEL_CAND;
        cmd.wr_en        = 1'b1;
        cmd.hole_to_cand = 1'b1;
        state_next       = S_WIN;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ hw/rtl/hhi_datapath.sv @@
// datapath: request registers, scan counters, slot store and result registers
module hhi_datapath import hhi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [1:0]         in_op,
  input  logic [HASH_W-1:0]  in_hash,
  input  logic [OFF_W-1:0]   in_start,
  input  logic [KV_W-1:0]    in_kv,
  input  logic [PBA_W-1:0]   in_pba,
  input  logic               out_ready,
  output stat_t              stat,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [OFF_W-1:0]   out_off,
  output logic [TAG_W-1:0]   out_tag,
  output logic [KV_W-1:0]    out_kv,
  output logic [PBA_W-1:0]   out_pba
);

  logic [1:0]             op;
  logic [BUCKET_BITS-1:0] bucket;
  logic [TAG_W-1:0]       tag;
  logic [OFF_W-1:0]       start;
  logic [KV_W-1:0]        kv;
  logic [PBA_W-1:0]       pba;
  logic [IDX_W-1:0]       idx;
  logic [CNT_W-1:0]       hole;
  logic [DIST_W-1:0]      hop_dist;
  logic [ADDR_W-1:0]      clr;
  logic [1:0]             res_status;
  logic [SLOT_W-1:0]      res_slot;

  logic [SLOT_W-1:0] rd_data;
  logic [SLOT_W-1:0] wr_data;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  idx_addr;
  logic [CNT_W-1:0]  cand;
  logic [CNT_W-1:0]  bucket_x;
  logic [OFF_W-1:0]  rd_off;
  logic [5:0]        moved_off;
  logic              rd_valid;
  logic              tag_hit;

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op     <= in_op;
      bucket <= in_hash[BUCKET_BITS-1:0];
      tag    <= in_hash[HASH_W-1 -: TAG_W];
      start  <= in_start;
      kv     <= in_kv;
      pba    <= in_pba;
    end
  end

  // window index, hole position and displacement distance
  always_ff @(posedge clk) begin
    if (cmd.idx_start) begin
      idx <= IDX_W'(start);
    end else if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.hole_init) begin
      hole <= bucket_x;
    end else if (cmd.hole_inc) begin
      hole <= hole + 1'b1;
    end else if (cmd.hole_to_cand) begin
      hole <= cand;
    end
    if (cmd.dist_init) begin
      hop_dist <= DIST_W'(HOP_RANGE - 1);
    end else if (cmd.dist_dec) begin
      hop_dist <= hop_dist - 1'b1;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_inc) begin
      clr <= clr + 1'b1;
    end
  end

  // address and write data selection
  assign bucket_x  = CNT_W'(bucket);
  assign idx_addr  = bucket_x + CNT_W'(idx);
  assign cand      = hole - CNT_W'(hop_dist);
  assign rd_off    = rd_data[OFF_LSB +: OFF_W];
  assign rd_valid  = rd_data[VALID_POS];
  assign moved_off = 6'(hop_dist) + 6'(rd_off);

  always_comb begin
    case (cmd.asel)
      ASEL_CLR:  addr = clr;
      ASEL_IDX:  addr = idx_addr[ADDR_W-1:0];
      ASEL_HOLE: addr = hole[ADDR_W-1:0];
      ASEL_CAND: addr = cand[ADDR_W-1:0];
      default:   addr = clr;
    endcase
    case (cmd.wsel)
      WSEL_MOVED: wr_data = {1'b1, moved_off[OFF_W-1:0], rd_data[TAG_LSB +: TAG_W],
                             rd_data[KV_LSB +: KV_W], rd_data[PBA_W-1:0]};
      WSEL_NEW:   wr_data = {1'b1, OFF_W'(hole - bucket_x), tag, kv, pba};
      default:    wr_data = '0;
    endcase
  end

  hhi_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(STORE_SLOTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(addr),
    .rd_data(rd_data)
  );

  // status toward the controller
  assign tag_hit = rd_valid && (6'(rd_off) == 6'(idx)) &&
                   (rd_data[TAG_LSB +: TAG_W] == tag);

  always_comb begin
    stat.op         = op;
    stat.start_oob  = 6'(start) >= 6'(HOP_RANGE);
    stat.lk_match   = tag_hit;
    stat.rm_match   = tag_hit && (rd_data[PBA_W-1:0] == pba);
    stat.idx_last   = idx == IDX_W'(HOP_RANGE - 1);
    stat.slot_valid = rd_valid;
    stat.hole_end   = hole == CNT_W'(STORE_SLOTS);
    stat.in_window  = (hole - bucket_x) < CNT_W'(HOP_RANGE);
    stat.cand_below = hole < (bucket_x + CNT_W'(hop_dist));
    stat.dist_zero  = hop_dist == '0;
    stat.move_ok    = rd_valid && (moved_off < 6'(HOP_RANGE));
    stat.clr_done   = clr == ADDR_W'(STORE_SLOTS - 1);
    stat.out_busy   = out_valid && !out_ready;
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_slot   <= cmd.res_use_slot ? rd_data : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_off    <= res_slot[OFF_LSB +: OFF_W];
      out_tag    <= res_slot[TAG_LSB +: TAG_W];
      out_kv     <= res_slot[KV_LSB +: KV_W];
      out_pba    <= res_slot[PBA_W-1:0];
    end
  end

endmodule

@@ hw/rtl/hopscotch_hash_index_unit.sv @@
// top level of the hopscotch hash index: stream ports, controller and datapath
// One transaction at a time. After reset a clearing pass writes every slot of the
// 2^BUCKET_BITS + HOP_RANGE slot store (1056 slots at the default sizes) with s_tready
// low. Each slot visit on the single store port issues the address, then checks the
// registered read data: a lookup scans the window from first_hop to its end, a remove
// scans the whole window, and an insert walks the slots to the first hole and then, per
// displacement, tries distances in turn, then clears the old slot and rechecks the window.
// The next request is taken while the previous result still waits on the master side.
module hopscotch_hash_index_unit import hhi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,   // hash[63:0], first_hop[68:64], kv_size[84:69], pba[118:85]
  input  logic [1:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // hit_offset[4:0], hit_tag[12:5], hit_kv_size[28:13],
                                  // hit_block[62:29]
  output logic [1:0]   m_tuser    // status
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_accept;

  logic [OFF_W-1:0] out_off;
  logic [TAG_W-1:0] out_tag;
  logic [KV_W-1:0]  out_kv;
  logic [PBA_W-1:0] out_pba;

  assign in_accept = s_tvalid && s_tready;

  hhi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_accept(in_accept),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  hhi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_op     (s_tuser),
    .in_hash   (s_tdata[63:0]),
    .in_start  (s_tdata[68:64]),
    .in_kv     (s_tdata[84:69]),
    .in_pba    (s_tdata[118:85]),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_status(m_tuser),
    .out_off   (out_off),
    .out_tag   (out_tag),
    .out_kv    (out_kv),
    .out_pba   (out_pba)
  );

  // result packing
  assign m_tdata = {1'b0, out_pba, out_kv, out_tag, out_off};

  // one transaction in flight: no new request right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("request accepted while another is in flight");

  // the single store port never reads and writes in one cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.wr_en))
    else $error("store read and write collide");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("pending result overwritten");

  // results carry only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOT_FOUND || m_tuser == ST_FULL))
    else $error("undefined status code");

endmodule
